[design/grpc_pkg.sv]
package grpc_pkg;

   localparam int BYTE_WIDTH      = 8;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [BYTE_WIDTH-1:0] STX_BYTE = 8'h02;
   localparam logic [BYTE_WIDTH-1:0] ETX_BYTE = 8'h03;
   localparam logic [BYTE_WIDTH-1:0] NAK_BYTE = 8'h15;

   // smallest length byte that still covers the fixed header fields
   localparam logic [BYTE_WIDTH-1:0] HEADER_LENGTH = 8'd4;
   // byte position of the last header byte (flags)
   localparam logic [BYTE_WIDTH-1:0] LAST_HEADER_POS = 8'd7;
   localparam logic [BYTE_WIDTH-1:0] TYPE_POS   = 8'd2;
   localparam logic [BYTE_WIDTH-1:0] LENGTH_POS = 8'd3;
   localparam logic [BYTE_WIDTH-1:0] RECORD_POS = 8'd4;
   localparam logic [BYTE_WIDTH-1:0] PAGE_POS   = 8'd5;

   localparam logic [BYTE_WIDTH-1:0] RESET_PKT_KIND   = 8'h57;
   localparam logic [BYTE_WIDTH-1:0] RESET_REC_KIND   = 8'h01;
   localparam logic [BYTE_WIDTH-1:0] RESET_PAGE_NUM   = 8'h11;
   localparam logic [BYTE_WIDTH-1:0] RESET_MIN_LENGTH = 8'd82;
   localparam logic [BYTE_WIDTH-1:0] RESET_MAX_LENGTH = 8'd106;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PKT_KIND   = 3'd0,
      CSR_REC_KIND   = 3'd1,
      CSR_PAGE_NUM   = 3'd2,
      CSR_MIN_LENGTH = 3'd3,
      CSR_MAX_LENGTH = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      PHASE_HUNT    = 3'd0,
      PHASE_HEADER  = 3'd1,
      PHASE_PAYLOAD = 3'd2,
      PHASE_CHECK   = 3'd3,
      PHASE_ETX     = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      STATUS_OK       = 3'd0,
      STATUS_NAK      = 3'd1,
      STATUS_LENGTH   = 3'd2,
      STATUS_ETX      = 3'd3,
      STATUS_TYPE     = 3'd4,
      STATUS_RECORD   = 3'd5,
      STATUS_PAGE     = 3'd6,
      STATUS_CHECKSUM = 3'd7
   } status_type;

endpackage

[design/gnss_reply_packet_checker.sv]
// an accepted byte's result is in the result register in the cycle after it is taken
// throughput: one byte per cycle while the result register is not stalled; the whole
//   check is a single registered pass (compare plus 8-bit add) between the frame state and the result register
// reset (synchronous, active high): hunting for start byte, counters and sum cleared,
//   result register empty, configuration registers back to their defaults
module gnss_reply_packet_checker (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_write_enable,
   input  logic [grpc_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [grpc_pkg::BYTE_WIDTH-1:0]         csr_write_data,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [grpc_pkg::BYTE_WIDTH-1:0]         req_rx_byte,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [grpc_pkg::BYTE_WIDTH-1:0]         rsp_payload_byte,
   output logic                                    rsp_payload_valid,
   output logic [grpc_pkg::BYTE_WIDTH-1:0]         rsp_payload_index,
   output logic                                    rsp_packet_done,
   output logic [2:0]                              rsp_packet_status
);
   import grpc_pkg::*;

   // configuration registers
   logic [BYTE_WIDTH-1:0] pkt_kind_ff;
   logic [BYTE_WIDTH-1:0] rec_kind_ff;
   logic [BYTE_WIDTH-1:0] page_num_ff;
   logic [BYTE_WIDTH-1:0] min_length_ff;
   logic [BYTE_WIDTH-1:0] max_length_ff;

   // frame state
   phase_type             phase_ff, phase_in;
   logic [BYTE_WIDTH-1:0] position_ff, position_in;
   logic [BYTE_WIDTH-1:0] sum_ff, sum_in;
   logic [BYTE_WIDTH-1:0] length_ff, length_in;
   status_type            error_ff, error_in;

   // result register
   logic                  rsp_valid_ff;
   logic [BYTE_WIDTH-1:0] rsp_payload_byte_ff, rsp_payload_byte_in;
   logic                  rsp_payload_valid_ff, rsp_payload_valid_in;
   logic [BYTE_WIDTH-1:0] rsp_payload_index_ff, rsp_payload_index_in;
   logic                  rsp_packet_done_ff, rsp_packet_done_in;
   status_type            rsp_packet_status_ff, rsp_packet_status_in;

   logic                  req_accept;
   logic                  length_bad;
   logic                  header_last;
   logic                  payload_last;
   logic [BYTE_WIDTH:0]   payload_next_count;
   logic [BYTE_WIDTH:0]   payload_length;

   // keep the lowest non-zero code, which is the highest priority fault
   function automatic status_type merge_error(input status_type current,
                                              input status_type code);
      if (current == STATUS_OK || code < current) begin
         return code;
      end
      return current;
   endfunction

   // the result register takes a new transfer when empty or draining this cycle
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   // length byte outside the window, or too short to hold the header fields
   assign length_bad = (req_rx_byte < HEADER_LENGTH) || (req_rx_byte < min_length_ff) ||
                       (req_rx_byte > max_length_ff);
   assign header_last = position_ff >= LAST_HEADER_POS;

   // payload ends once position + 1 reaches length - 4 (length is above 4 here)
   assign payload_next_count = {1'b0, position_ff} + {{BYTE_WIDTH{1'b0}}, 1'b1};
   assign payload_length     = {1'b0, length_ff} - {1'b0, HEADER_LENGTH};
   assign payload_last       = payload_next_count >= payload_length;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PHASE_HEADER: begin
            if (position_ff == LENGTH_POS && length_bad) begin
               phase_in = PHASE_HUNT;
            end else if (header_last) begin
               phase_in = (length_ff > HEADER_LENGTH) ? PHASE_PAYLOAD : PHASE_CHECK;
            end
         end
         PHASE_PAYLOAD: begin
            if (payload_last) begin
               phase_in = PHASE_CHECK;
            end
         end
         PHASE_CHECK: begin
            phase_in = PHASE_ETX;
         end
         PHASE_ETX: begin
            phase_in = PHASE_HUNT;
         end
         default: begin
            // hunting, and any unused code behaves as hunting
            phase_in = (req_rx_byte == STX_BYTE) ? PHASE_HEADER : PHASE_HUNT;
         end
      endcase
   end

   // datapath and result fields
   always_comb begin
      position_in          = position_ff;
      sum_in               = sum_ff;
      length_in            = length_ff;
      error_in             = error_ff;
      rsp_payload_byte_in  = '0;
      rsp_payload_valid_in = 1'b0;
      rsp_payload_index_in = '0;
      rsp_packet_done_in   = 1'b0;
      rsp_packet_status_in = STATUS_OK;
      unique case (phase_ff)
         PHASE_HEADER: begin
            sum_in = sum_ff + req_rx_byte;
            if (position_ff == TYPE_POS && req_rx_byte != pkt_kind_ff) begin
               error_in = merge_error(error_ff, STATUS_TYPE);
            end
            if (position_ff == RECORD_POS && req_rx_byte != rec_kind_ff) begin
               error_in = merge_error(error_ff, STATUS_RECORD);
            end
            if (position_ff == PAGE_POS && req_rx_byte != page_num_ff) begin
               error_in = merge_error(error_ff, STATUS_PAGE);
            end
            if (position_ff == LENGTH_POS) begin
               length_in = req_rx_byte;
            end
            if (position_ff == LENGTH_POS && length_bad) begin
               // frame dropped straight away
               rsp_packet_done_in   = 1'b1;
               rsp_packet_status_in = STATUS_LENGTH;
               position_in          = '0;
            end else if (header_last) begin
               position_in = '0;
            end else begin
               position_in = position_ff + 8'd1;
            end
         end
         PHASE_PAYLOAD: begin
            sum_in               = sum_ff + req_rx_byte;
            rsp_payload_byte_in  = req_rx_byte;
            rsp_payload_valid_in = 1'b1;
            rsp_payload_index_in = position_ff;
            position_in          = payload_last ? '0 : position_ff + 8'd1;
         end
         PHASE_CHECK: begin
            if (req_rx_byte != sum_ff) begin
               error_in = merge_error(error_ff, STATUS_CHECKSUM);
            end
         end
         PHASE_ETX: begin
            rsp_packet_done_in   = 1'b1;
            rsp_packet_status_in = (req_rx_byte != ETX_BYTE) ?
                                   merge_error(error_ff, STATUS_ETX) : error_ff;
            error_in             = rsp_packet_status_in;
            position_in          = '0;
         end
         default: begin
            if (req_rx_byte == STX_BYTE) begin
               // status is frame position one, so the counter starts there
               position_in = 8'd1;
               sum_in      = '0;
               length_in   = '0;
               error_in    = STATUS_OK;
            end else if (req_rx_byte == NAK_BYTE) begin
               rsp_packet_done_in   = 1'b1;
               rsp_packet_status_in = STATUS_NAK;
            end
         end
      endcase
   end

   // configuration writes; indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         pkt_kind_ff   <= RESET_PKT_KIND;
         rec_kind_ff   <= RESET_REC_KIND;
         page_num_ff   <= RESET_PAGE_NUM;
         min_length_ff <= RESET_MIN_LENGTH;
         max_length_ff <= RESET_MAX_LENGTH;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PKT_KIND:   pkt_kind_ff   <= csr_write_data;
            CSR_REC_KIND:   rec_kind_ff   <= csr_write_data;
            CSR_PAGE_NUM:   page_num_ff   <= csr_write_data;
            CSR_MIN_LENGTH: min_length_ff <= csr_write_data;
            CSR_MAX_LENGTH: max_length_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // frame state advances on every accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PHASE_HUNT;
         position_ff <= '0;
         sum_ff      <= '0;
         length_ff   <= '0;
         error_ff    <= STATUS_OK;
      end else if (req_accept) begin
         phase_ff    <= phase_in;
         position_ff <= position_in;
         sum_ff      <= sum_in;
         length_ff   <= length_in;
         error_ff    <= error_in;
      end
   end

   // result register: filled on accept, emptied on an unstalled transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_payload_byte_ff  <= rsp_payload_byte_in;
         rsp_payload_valid_ff <= rsp_payload_valid_in;
         rsp_payload_index_ff <= rsp_payload_index_in;
         rsp_packet_done_ff   <= rsp_packet_done_in;
         rsp_packet_status_ff <= rsp_packet_status_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_payload_byte  = rsp_payload_byte_ff;
   assign rsp_payload_valid = rsp_payload_valid_ff;
   assign rsp_payload_index = rsp_payload_index_ff;
   assign rsp_packet_done   = rsp_packet_done_ff;
   assign rsp_packet_status = rsp_packet_status_ff;

   // a byte taken in payload phase comes out as a payload transfer
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && phase_ff == PHASE_PAYLOAD) |=> (rsp_valid_ff && rsp_payload_valid_ff))
      else $error("payload byte not marked as payload");

   // a payload byte never closes a frame
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_payload_valid_ff && rsp_packet_done_ff))
      else $error("payload and frame end on one transfer");

   // a status code only travels with a frame end
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_packet_done_ff) |-> (rsp_packet_status_ff == STATUS_OK))
      else $error("status without frame end");

   // a stalled result holds while the input side is held off
   assert property (@(posedge clock) disable iff (reset)
      req_stall |=> (rsp_valid_ff && $stable(rsp_packet_status_ff) &&
                     $stable(rsp_payload_byte_ff)))
      else $error("result register changed while full");

endmodule
